[sv/imu_pkg.sv]
package imu_pkg;

  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned DATA_LEN  = 6;
  localparam int unsigned FILL_W    = $clog2(FRAME_LEN);

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic signed [15:0] RATE_SCALE  = 16'sd20000;
  localparam logic signed [15:0] ANGLE_SCALE = 16'sd1800;
  localparam int unsigned FULL_SCALE_LOG2 = 15;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_DISCARD = 3'd1;
  localparam logic [2:0] ST_CKFAIL  = 3'd2;
  localparam logic [2:0] ST_OTHER   = 3'd3;
  localparam logic [2:0] ST_RATE    = 3'd4;
  localparam logic [2:0] ST_ANGLE   = 3'd5;

  localparam int unsigned CNT_BYTES   = 0;
  localparam int unsigned CNT_HEADERS = 1;
  localparam int unsigned CNT_DISCARD = 2;
  localparam int unsigned CNT_CKFAIL  = 3;
  localparam int unsigned CNT_GOOD    = 4;
  localparam int unsigned CNT_ANGLE   = 5;
  localparam int unsigned CNT_RATE    = 6;
  localparam int unsigned NUM_CNT     = 7;

endpackage

[sv/imu_if.sv]
interface imu_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] axis_x_value;
  logic signed [15:0] axis_y_value;
  logic signed [15:0] axis_z_value;
  logic [31:0]        bytes_seen;
  logic [31:0]        headers_seen;
  logic [31:0]        bytes_discarded;
  logic [31:0]        checksum_failures;
  logic [31:0]        good_frames;
  logic [31:0]        angle_frames;
  logic [31:0]        rate_frames;

  modport source (
    output valid, output status, output axis_x_value, output axis_y_value,
    output axis_z_value, output bytes_seen, output headers_seen,
    output bytes_discarded, output checksum_failures, output good_frames,
    output angle_frames, output rate_frames, input ready
  );
  modport sink (
    input valid, input status, input axis_x_value, input axis_y_value,
    input axis_z_value, input bytes_seen, input headers_seen,
    input bytes_discarded, input checksum_failures, input good_frames,
    input angle_frames, input rate_frames, output ready
  );
endinterface

[sv/imu_frame_parser.sv]
// channel | dir | handshake        | payload
// rx      | in  | valid / ready    | rx_byte
// res     | out | valid / ready    | status, axis x/y/z, seven event counters
//
// One request per cycle unless stalled; each request yields one result next cycle.
// Throughput is set by the single result register: rx.ready is high while
// that register is empty or being taken, so a stalled result holds off rx.
// Scaling (one 16x16 multiply per axis) runs from stored frame bytes in the
// cycle the checksum byte arrives. Synchronous reset clears fill level,
// counters and result valid; frame bytes are not cleared.
module imu_frame_parser
  import imu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  imu_rx_if.sink     rx,
  imu_res_if.source  res
);

  logic [FILL_W-1:0] fill_level, fill_level_next, fill_eff;
  logic [7:0]        sum, sum_next;
  logic [7:0]        type_byte, type_byte_next;
  logic [7:0]        data [DATA_LEN];
  logic [7:0]        data_next [DATA_LEN];
  logic [31:0]       cnt [NUM_CNT];
  logic [31:0]       cnt_next [NUM_CNT];
  logic [2:0]        status, status_next;
  logic signed [15:0] ax, ay, az;
  logic signed [15:0] ax_next, ay_next, az_next;
  logic signed [15:0] sx, sy, sz;
  logic [2:0]        didx;
  logic              acc;
  logic              is_angle;

  assign rx.ready = !res.valid || res.ready;
  assign acc      = rx.valid && rx.ready;
  assign is_angle = (type_byte == TYPE_ANGLE);
  assign fill_eff = (fill_level >= FILL_W'(FRAME_LEN)) ? '0 : fill_level;
  assign didx     = 3'(fill_eff - FILL_W'(2));

  imu_scale u_sx (.word({data[1], data[0]}), .angle(is_angle), .value(sx));
  imu_scale u_sy (.word({data[3], data[2]}), .angle(is_angle), .value(sy));
  imu_scale u_sz (.word({data[5], data[4]}), .angle(is_angle), .value(sz));

  always_comb begin
    fill_level_next = fill_eff;
    sum_next        = sum;
    type_byte_next  = type_byte;
    data_next       = data;
    cnt_next        = cnt;
    status_next     = ST_PENDING;
    ax_next         = '0;
    ay_next         = '0;
    az_next         = '0;

    cnt_next[CNT_BYTES] = cnt[CNT_BYTES] + 32'd1;

    if (fill_eff == '0 && rx.rx_byte != HDR_BYTE) begin
      cnt_next[CNT_DISCARD] = cnt[CNT_DISCARD] + 32'd1;
      status_next           = ST_DISCARD;
    end else if (fill_eff == '0 || (fill_eff == FILL_W'(1) && rx.rx_byte == HDR_BYTE)) begin
      cnt_next[CNT_HEADERS] = cnt[CNT_HEADERS] + 32'd1;
      sum_next              = rx.rx_byte;
      fill_level_next       = FILL_W'(1);
    end else if (fill_eff == FILL_W'(FRAME_LEN - 1)) begin
      fill_level_next = '0;
      if (sum != rx.rx_byte) begin
        cnt_next[CNT_CKFAIL] = cnt[CNT_CKFAIL] + 32'd1;
        status_next          = ST_CKFAIL;
      end else begin
        cnt_next[CNT_GOOD] = cnt[CNT_GOOD] + 32'd1;
        if (type_byte == TYPE_RATE) begin
          cnt_next[CNT_RATE] = cnt[CNT_RATE] + 32'd1;
          status_next        = ST_RATE;
          ax_next = sx;
          ay_next = sy;
          az_next = sz;
        end else if (type_byte == TYPE_ANGLE) begin
          cnt_next[CNT_ANGLE] = cnt[CNT_ANGLE] + 32'd1;
          status_next         = ST_ANGLE;
          ax_next = sx;
          ay_next = sy;
          az_next = sz;
        end else begin
          status_next = ST_OTHER;
        end
      end
    end else begin
      sum_next        = sum + rx.rx_byte;
      fill_level_next = fill_eff + FILL_W'(1);
      if (fill_eff == FILL_W'(1)) begin
        type_byte_next = rx.rx_byte;
      end
      for (int i = 0; i < DATA_LEN; i++) begin
        if (fill_eff >= FILL_W'(2) && fill_eff <= FILL_W'(DATA_LEN + 1)
            && didx == 3'(i)) begin
          data_next[i] = rx.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
      res.valid  <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (acc) begin
        fill_level <= fill_level_next;
        cnt        <= cnt_next;
        res.valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      sum       <= sum_next;
      type_byte <= type_byte_next;
      data      <= data_next;
      status    <= status_next;
      ax        <= ax_next;
      ay        <= ay_next;
      az        <= az_next;
    end
  end

  // counters only move on a request, which needs the result slot free
  assign res.status            = status;
  assign res.axis_x_value      = ax;
  assign res.axis_y_value      = ay;
  assign res.axis_z_value      = az;
  assign res.bytes_seen        = cnt[CNT_BYTES];
  assign res.headers_seen      = cnt[CNT_HEADERS];
  assign res.bytes_discarded   = cnt[CNT_DISCARD];
  assign res.checksum_failures = cnt[CNT_CKFAIL];
  assign res.good_frames       = cnt[CNT_GOOD];
  assign res.angle_frames      = cnt[CNT_ANGLE];
  assign res.rate_frames       = cnt[CNT_RATE];

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !rx.ready)
    else $error("request taken while result stalled");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(FRAME_LEN - 1))
    else $error("fill level out of range");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    acc && fill_level == FILL_W'(FRAME_LEN - 1) |=> fill_level == '0)
    else $error("fill level not cleared at frame end");

  a_axes_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && status != ST_RATE && status != ST_ANGLE
      |-> ax == '0 && ay == '0 && az == '0)
    else $error("axis values nonzero without update");

  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    acc |=> cnt[CNT_BYTES] == $past(cnt[CNT_BYTES]) + 32'd1)
    else $error("byte counter did not advance");

endmodule

[sv/imu_scale.sv]
module imu_scale
  import imu_pkg::*;
(
  input  logic signed [15:0] word,
  input  logic               angle,
  output logic signed [15:0] value
);

  logic signed [15:0] scale;
  logic signed [31:0] prod;
  logic signed [31:0] biased;

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    scale  = angle ? ANGLE_SCALE : RATE_SCALE;
    prod   = 32'(word) * 32'(scale);
    biased = prod + (prod[31] ? 32'sd32767 : 32'sd0);
    value  = 16'(biased >>> FULL_SCALE_LOG2);
  end

endmodule

[tb/sv/tb.sv]
module tb
  import imu_pkg::*;
();

  localparam int FULL_SCALE   = 1 << FULL_SCALE_LOG2;
  localparam int PHASE_ITEMS  = 510;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [15:0]       axis_x;
    logic signed [15:0]       axis_y;
    logic signed [15:0]       axis_z;
    logic [NUM_CNT-1:0][31:0] counts;
  } parser_report_t;

  class frame_scoreboard;
    logic [7:0]               frame_bytes [FRAME_LEN];
    int unsigned              fill;
    logic [NUM_CNT-1:0][31:0] event_count;
    parser_report_t           pending_reports [$];
    int unsigned              mismatches;
    int unsigned              status_hits [6];
    string                    counter_name [NUM_CNT];

    function new();
      fill = 0;
      event_count = '0;
      mismatches = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      foreach (status_hits[i]) status_hits[i] = 0;
      counter_name = '{"bytes_seen", "headers_seen", "bytes_discarded",
                       "checksum_failures", "good_frames", "angle_frames",
                       "rate_frames"};
    endfunction

    // signed LE word at pos, scaled to tenths, truncated toward zero
    function logic signed [15:0] tenths(int unsigned pos, int scale);
      logic signed [15:0] word;
      int prod;
      word = {frame_bytes[pos + 1], frame_bytes[pos]};
      prod = int'(word) * scale;
      return 16'(prod / FULL_SCALE);
    endfunction

    function parser_report_t parse_byte(logic [7:0] b);
      parser_report_t rep;
      logic [7:0] sum;
      int unsigned k;
      rep = '0;
      rep.status = ST_PENDING;
      if (fill >= FRAME_LEN) fill = 0;
      event_count[CNT_BYTES] += 1;
      if (fill == 0 && b != HDR_BYTE) begin
        event_count[CNT_DISCARD] += 1;
        rep.status = ST_DISCARD;
      end else if (fill == 1 && b == HDR_BYTE) begin
        frame_bytes[0] = b;
        event_count[CNT_HEADERS] += 1;
      end else begin
        if (fill == 0) event_count[CNT_HEADERS] += 1;
        frame_bytes[fill] = b;
        fill++;
        if (fill >= FRAME_LEN) begin
          fill = 0;
          sum = 8'h00;
          for (k = 0; k < FRAME_LEN - 1; k++) sum += frame_bytes[k];
          if (sum != frame_bytes[FRAME_LEN - 1]) begin
            event_count[CNT_CKFAIL] += 1;
            rep.status = ST_CKFAIL;
          end else begin
            event_count[CNT_GOOD] += 1;
            if (frame_bytes[1] == TYPE_RATE) begin
              rep.axis_x = tenths(2, int'(RATE_SCALE));
              rep.axis_y = tenths(4, int'(RATE_SCALE));
              rep.axis_z = tenths(6, int'(RATE_SCALE));
              event_count[CNT_RATE] += 1;
              rep.status = ST_RATE;
            end else if (frame_bytes[1] == TYPE_ANGLE) begin
              rep.axis_x = tenths(2, int'(ANGLE_SCALE));
              rep.axis_y = tenths(4, int'(ANGLE_SCALE));
              rep.axis_z = tenths(6, int'(ANGLE_SCALE));
              event_count[CNT_ANGLE] += 1;
              rep.status = ST_ANGLE;
            end else begin
              rep.status = ST_OTHER;
            end
          end
        end
      end
      rep.counts = event_count;
      return rep;
    endfunction

    function void note_request(logic [7:0] b);
      pending_reports.push_back(parse_byte(b));
    endfunction

    function int unsigned outstanding();
      return pending_reports.size();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(parser_report_t got);
      parser_report_t want;
      int unsigned i;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding, status %0d", $time, got.status);
        return;
      end
      want = pending_reports.pop_front();
      if (want.status < 6) status_hits[want.status]++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("axis_x_value", 32'(want.axis_x), 32'(got.axis_x));
      compare_field("axis_y_value", 32'(want.axis_y), 32'(got.axis_y));
      compare_field("axis_z_value", 32'(want.axis_z), 32'(got.axis_z));
      for (i = 0; i < NUM_CNT; i++)
        compare_field(counter_name[i], want.counts[i], got.counts[i]);
    endfunction
  endclass

  logic clk;
  logic rst;
  imu_rx_if  rx_ch ();
  imu_res_if res_ch ();

  imu_frame_parser u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  frame_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              hold_request;
  int unsigned     items_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", sb.outstanding());
    $display("imu_frame_parser verification failed");
    $finish;
  end

  function automatic parser_report_t capture_report();
    parser_report_t rep;
    rep.status               = res_ch.status;
    rep.axis_x               = res_ch.axis_x_value;
    rep.axis_y               = res_ch.axis_y_value;
    rep.axis_z               = res_ch.axis_z_value;
    rep.counts[CNT_BYTES]    = res_ch.bytes_seen;
    rep.counts[CNT_HEADERS]  = res_ch.headers_seen;
    rep.counts[CNT_DISCARD]  = res_ch.bytes_discarded;
    rep.counts[CNT_CKFAIL]   = res_ch.checksum_failures;
    rep.counts[CNT_GOOD]     = res_ch.good_frames;
    rep.counts[CNT_ANGLE]    = res_ch.angle_frames;
    rep.counts[CNT_RATE]     = res_ch.rate_frames;
    return rep;
  endfunction

  // result side: checks, random stalls, long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) sb.check_result(capture_report());
      if (hold_left == 0 && hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_request(b);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] kind, input logic [15:0] wx, wy, wz,
                            input logic [7:0] t0, t1, input bit corrupt);
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] sum;
    int unsigned k;
    fr = '{HDR_BYTE, kind, wx[7:0], wx[15:8], wy[7:0], wy[15:8],
           wz[7:0], wz[15:8], t0, t1, 8'h00};
    sum = 8'h00;
    for (k = 0; k < FRAME_LEN - 1; k++) sum += fr[k];
    fr[FRAME_LEN - 1] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (k = 0; k < FRAME_LEN; k++) send_byte(fr[k]);
  endtask

  task automatic pause_until_drained();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_kind();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return TYPE_RATE;
    if (p < 80) return TYPE_ANGLE;
    return 8'($urandom);
  endfunction

  task automatic send_random_chunk();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 72) begin
      send_frame(pick_kind(), pick_word(), pick_word(), pick_word(),
                 8'($urandom), 8'($urandom), $urandom_range(99) < 15);
    end else if (pick < 82) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom));
    end else if (pick < 90) begin
      // frame cut short; the next header lands inside it
      send_byte(HDR_BYTE);
      n = $urandom_range(1, 9);
      repeat (n) send_byte(8'($urandom));
    end else if (pick < 95) begin
      send_byte(HDR_BYTE);
      send_frame(pick_kind(), pick_word(), pick_word(), pick_word(),
                 8'($urandom), 8'($urandom), 1'b0);
    end else begin
      send_frame($urandom_range(1) ? TYPE_RATE : TYPE_ANGLE, 16'h5555, pick_word(),
                 16'h5555, HDR_BYTE, HDR_BYTE, 1'b0);
    end
  endtask

  initial begin
    int unsigned phase_start;
    bit hold_issued;
    sb = new();
    send_idle_pct = 35;
    recv_idle_pct = 68;
    hold_request  = 1'b0;
    items_sent    = 0;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    res_ch.ready  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(HDR_BYTE);
    send_frame(TYPE_RATE, 16'h8000, 16'h7FFF, 16'h5555, HDR_BYTE, 8'hFF, 1'b0);
    send_frame(TYPE_ANGLE, 16'hFFFF, 16'h0001, 16'h8001, 8'h00, HDR_BYTE, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = items_sent;
      hold_issued = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (!hold_issued && items_sent - phase_start >= PHASE_ITEMS / 3) begin
          hold_request = 1'b1;
          hold_issued  = 1'b1;
        end
        send_random_chunk();
      end
      pause_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes under three stall mixes with long result hold-offs",
             items_sent);
    $display("Frames: %0d rate, %0d angle, %0d other type, %0d bad checksum; %0d discards",
             sb.status_hits[ST_RATE], sb.status_hits[ST_ANGLE], sb.status_hits[ST_OTHER],
             sb.status_hits[ST_CKFAIL], sb.status_hits[ST_DISCARD]);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("imu_frame_parser verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.outstanding());
      $display("imu_frame_parser verification failed");
    end
    $finish;
  end

endmodule
